@@ hw/rtl/hvd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the haversine distance core.
package hvd_pkg;

   // Number of micro-rotations in each CORDIC pipeline
   localparam int CORDIC_STAGES = 24;
   // Result bits of the integer square root, one per stage
   localparam int ISQRT_STEPS   = 31;

   // Datapath word for Q30 sines, cosines and angles
   typedef logic signed [33:0] cw_type;
   // Wider word for the vectoring CORDIC, whose magnitude grows by the CORDIC gain
   typedef logic signed [34:0] vw_type;

   typedef struct packed {
      logic [19:0] quo;
      logic [6:0]  rem;
   } div90_type;

   // floor(x / 90) is exact for x below 2^26 with this reciprocal and a shift of 33
   localparam logic [26:0] DIV90_RECIP = 27'd95443718;

   localparam logic [31:0] PI_Q30      = 32'hC90F_DAA2;
   localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

   // atan(2^-i) in Q30, rounded to nearest
   localparam cw_type ATAN_Q30 [0:31] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128,
      34'sd64,        34'sd32,        34'sd16,        34'sd8,
      34'sd4,         34'sd2,         34'sd1,         34'sd1
   };

   // Integer floor square root, used only to build constants
   function automatic logic [63:0] isqrt_const(input logic [63:0] n_arg);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] b;
      n   = n_arg;
      res = 64'd0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // floor(2^30 * sqrt(1 + 4^-i))
   function automatic logic [63:0] gain_root(input int i);
      return isqrt_const((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
   endfunction

   localparam logic [63:0] GainF0  = gain_root(0);
   localparam logic [63:0] GainF1  = gain_root(1);
   localparam logic [63:0] GainF2  = gain_root(2);
   localparam logic [63:0] GainF3  = gain_root(3);
   localparam logic [63:0] GainF4  = gain_root(4);
   localparam logic [63:0] GainF5  = gain_root(5);
   localparam logic [63:0] GainF6  = gain_root(6);
   localparam logic [63:0] GainF7  = gain_root(7);
   localparam logic [63:0] GainF8  = gain_root(8);
   localparam logic [63:0] GainF9  = gain_root(9);
   localparam logic [63:0] GainF10 = gain_root(10);
   localparam logic [63:0] GainF11 = gain_root(11);
   localparam logic [63:0] GainF12 = gain_root(12);
   localparam logic [63:0] GainF13 = gain_root(13);
   localparam logic [63:0] GainF14 = gain_root(14);

   // Rounded reciprocal of the gain, step by step; from stage 15 on the
   // per-stage factor floors to exactly one and the value stays put.
   localparam logic [63:0] GainQ0  = 64'd1 << 30;
   localparam logic [63:0] GainQ1  = ((GainQ0  << 30) + (GainF0  >> 1)) / GainF0;
   localparam logic [63:0] GainQ2  = ((GainQ1  << 30) + (GainF1  >> 1)) / GainF1;
   localparam logic [63:0] GainQ3  = ((GainQ2  << 30) + (GainF2  >> 1)) / GainF2;
   localparam logic [63:0] GainQ4  = ((GainQ3  << 30) + (GainF3  >> 1)) / GainF3;
   localparam logic [63:0] GainQ5  = ((GainQ4  << 30) + (GainF4  >> 1)) / GainF4;
   localparam logic [63:0] GainQ6  = ((GainQ5  << 30) + (GainF5  >> 1)) / GainF5;
   localparam logic [63:0] GainQ7  = ((GainQ6  << 30) + (GainF6  >> 1)) / GainF6;
   localparam logic [63:0] GainQ8  = ((GainQ7  << 30) + (GainF7  >> 1)) / GainF7;
   localparam logic [63:0] GainQ9  = ((GainQ8  << 30) + (GainF8  >> 1)) / GainF8;
   localparam logic [63:0] GainQ10 = ((GainQ9  << 30) + (GainF9  >> 1)) / GainF9;
   localparam logic [63:0] GainQ11 = ((GainQ10 << 30) + (GainF10 >> 1)) / GainF10;
   localparam logic [63:0] GainQ12 = ((GainQ11 << 30) + (GainF11 >> 1)) / GainF11;
   localparam logic [63:0] GainQ13 = ((GainQ12 << 30) + (GainF12 >> 1)) / GainF12;
   localparam logic [63:0] GainQ14 = ((GainQ13 << 30) + (GainF13 >> 1)) / GainF13;
   localparam logic [63:0] GainQ15 = ((GainQ14 << 30) + (GainF14 >> 1)) / GainF14;

   localparam cw_type GAIN_INV_Q30 = cw_type'(GainQ15[33:0]);

   // Quotient and remainder by 90 for values below 2^26
   function automatic div90_type div90(input logic [25:0] x);
      logic [52:0] prod;
      logic [25:0] back;
      div90_type   d;
      prod  = {27'd0, x} * {26'd0, DIV90_RECIP};
      d.quo = prod[52:33];
      back  = 26'({6'd0, d.quo} * 26'd90);
      d.rem = 7'(x - back);
      return d;
   endfunction

   // Q30 product, rounded to nearest with ties away from zero
   function automatic cw_type mul_q30(input cw_type a, input cw_type b);
      logic        neg;
      logic [33:0] ua;
      logic [33:0] ub;
      logic [67:0] p;
      logic [67:0] r;
      neg = a[33] ^ b[33];
      ua  = a[33] ? 34'(-a) : 34'(a);
      ub  = b[33] ? 34'(-b) : 34'(b);
      p   = {34'd0, ua} * {34'd0, ub};
      r   = (p + 68'd536870912) >> 30;
      return neg ? -cw_type'(r[33:0]) : cw_type'(r[33:0]);
   endfunction

endpackage

@@ hw/rtl/haversine_distance_core.sv @@
// Top level of the haversine great-circle distance core.
//
// Usage: each req_ transaction carries two points (longitude and latitude,
// signed, 2^-20 degree) and yields exactly one rsp_ transaction holding the
// great-circle distance in millimetres, in the order the requests arrived.
// A transaction moves at a rising edge where valid is high and stall is low.
// The sphere radius in metres is written through the csr_ channel, which is
// always ready; write it only while no request is in flight.
// Pipeline from request acceptance to rsp_valid: 3 phase stages,
// 26 sine/cosine CORDIC stages, 3 product stages, 31 square-root stages,
// 24 vectoring CORDIC stages, one scaling stage and the output buffer.
// Throughput: one transaction per cycle while req_stall is low.
// A two-entry output buffer lets the pipeline keep advancing while a result
// waits; once both entries are full the whole pipeline holds and req_stall
// rises, so a stall loses and repeats nothing.
// Reset (synchronous, active high) empties the pipeline and the output
// buffer and loads the default radius of 6371297 m.
module haversine_distance_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [28:0] req_first_longitude,
   input  logic signed [27:0] req_first_latitude,
   input  logic signed [28:0] req_second_longitude,
   input  logic signed [27:0] req_second_latitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [35:0]        rsp_distance_mm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_sphere_radius_m
);

   // Trig lanes: cosines of both latitudes, sines of both half differences
   localparam int LaneLat1 = 0;
   localparam int LaneLat2 = 1;
   localparam int LaneDlat = 2;
   localparam int LaneDlon = 3;
   localparam int Lanes    = 4;

   localparam logic [23:0] RADIUS_RESET = 24'd6371297;

   logic        enable;
   logic        accept;
   logic [23:0] radius_ff;

   logic signed [29:0] lane_angle [0:Lanes-1];
   logic               lane_half  [0:Lanes-1];
   logic               lane_sine  [0:Lanes-1];
   logic               ph_valid   [0:Lanes-1];
   logic [31:0]        ph_value   [0:Lanes-1];
   logic [Lanes-1:0]   trig_valid;
   hvd_pkg::cw_type    trig_value [0:Lanes-1];

   // Haversine product stages
   logic            m1_v_ff, m2_v_ff, m3_v_ff;
   hvd_pkg::cw_type sl2_ff, sn2_ff, cc_ff;
   hvd_pkg::cw_type sl2b_ff, term_ff;
   logic [30:0]     a_ff, b_ff;
   hvd_pkg::cw_type a_sum;
   logic [30:0]     a_in;

   logic        sq_a_valid, sq_b_valid;
   logic [30:0] root_a, root_b;
   logic        vec_valid;
   hvd_pkg::cw_type vec_angle;

   // Scaling stage and output buffer
   logic [30:0] z_clamp;
   logic        p_v_ff;
   logic [54:0] p_ff;
   logic [61:0] scaled;
   logic [35:0] push_data;
   logic        push, pop;
   logic [1:0]  count_ff, count_in;
   logic [35:0] slot0_ff, slot0_in, slot1_ff, slot1_in;

   // Advance the whole pipeline unless both output entries are taken
   assign enable    = (count_ff != 2'd2);
   assign req_stall = !enable;
   assign accept    = req_valid && enable;

   // Configuration: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_sphere_radius_m;
      end
   end

   // Lane set-up: full-turn phases for latitudes, half-turn for differences
   always_comb begin
      lane_angle[LaneLat1] = 30'(req_first_latitude);
      lane_angle[LaneLat2] = 30'(req_second_latitude);
      lane_angle[LaneDlat] = 30'(req_second_latitude) - 30'(req_first_latitude);
      lane_angle[LaneDlon] = 30'(req_second_longitude) - 30'(req_first_longitude);
      lane_half[LaneLat1]  = 1'b0;
      lane_half[LaneLat2]  = 1'b0;
      lane_half[LaneDlat]  = 1'b1;
      lane_half[LaneDlon]  = 1'b1;
      lane_sine[LaneLat1]  = 1'b0;
      lane_sine[LaneLat2]  = 1'b0;
      lane_sine[LaneDlat]  = 1'b1;
      lane_sine[LaneDlon]  = 1'b1;
   end

   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      hvd_phase u_phase (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (accept),
         .angle     (lane_angle[l]),
         .half_turn (lane_half[l]),
         .out_valid (ph_valid[l]),
         .phase     (ph_value[l])
      );

      hvd_sincos u_sincos (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (ph_valid[l]),
         .phase     (ph_value[l]),
         .sel_sine  (lane_sine[l]),
         .out_valid (trig_valid[l]),
         .trig      (trig_value[l])
      );
   end

   // a = sin^2(dlat/2) + cos(lat1)cos(lat2)sin^2(dlon/2), clamped to [0, 1]
   always_comb begin
      a_sum = sl2b_ff + term_ff;
      if (a_sum[33]) begin
         a_in = '0;
      end else if (a_sum > hvd_pkg::cw_type'({3'd0, hvd_pkg::ONE_Q30})) begin
         a_in = hvd_pkg::ONE_Q30;
      end else begin
         a_in = a_sum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else if (enable) begin
         m1_v_ff <= &trig_valid;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sl2_ff  <= hvd_pkg::mul_q30(trig_value[LaneDlat], trig_value[LaneDlat]);
         sn2_ff  <= hvd_pkg::mul_q30(trig_value[LaneDlon], trig_value[LaneDlon]);
         cc_ff   <= hvd_pkg::mul_q30(trig_value[LaneLat1], trig_value[LaneLat2]);
         sl2b_ff <= sl2_ff;
         term_ff <= hvd_pkg::mul_q30(cc_ff, sn2_ff);
         a_ff    <= a_in;
         b_ff    <= hvd_pkg::ONE_Q30 - a_in;
      end
   end

   hvd_sqrt u_sqrt_a (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (m3_v_ff),
      .value     (a_ff),
      .out_valid (sq_a_valid),
      .root      (root_a)
   );

   hvd_sqrt u_sqrt_b (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (m3_v_ff),
      .value     (b_ff),
      .out_valid (sq_b_valid),
      .root      (root_b)
   );

   // Half the central angle: atan2(sqrt(a), sqrt(1 - a))
   hvd_vector u_vector (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (sq_a_valid && sq_b_valid),
      .x_val     (root_b),
      .y_val     (root_a),
      .out_valid (vec_valid),
      .angle     (vec_angle)
   );

   // Clamp to [0, pi/2] and scale by the radius
   always_comb begin
      if (vec_angle[33]) begin
         z_clamp = '0;
      end else if (vec_angle > hvd_pkg::cw_type'({3'd0, hvd_pkg::HALF_PI_Q30})) begin
         z_clamp = hvd_pkg::HALF_PI_Q30;
      end else begin
         z_clamp = vec_angle[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (enable) begin
         p_v_ff <= vec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= {31'd0, radius_ff} * {24'd0, z_clamp};
      end
   end

   // mm = R * c_half * 2000 / 2^30 = (p * 125 + 2^25) >> 26, rounded half up
   always_comb begin
      scaled    = ({7'd0, p_ff} << 7) - ({7'd0, p_ff} << 1) - {7'd0, p_ff};
      push_data = 36'((scaled + 62'd33554432) >> 26);
   end

   // Two-entry output buffer; the head is the presented transaction
   assign push = enable && p_v_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      unique case (count_ff)
         2'd0: begin
            if (push) begin
               slot0_in = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (pop && push) begin
               slot0_in = push_data;
            end else if (pop) begin
               count_in = 2'd0;
            end else if (push) begin
               slot1_in = push_data;
               count_in = 2'd2;
            end
         end
         2'd2: begin
            if (pop) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_distance_mm = slot0_ff;

endmodule

@@ hw/rtl/hvd_phase.sv @@
// Conversion of a signed angle in 2^-20 degree to a phase in 2^-32 turn.
module hvd_phase (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic signed [29:0] angle,
   input  logic              half_turn,
   output logic              out_valid,
   output logic [31:0]       phase
);

   logic        v1_ff, v2_ff, v3_ff;
   logic        neg1_ff, neg2_ff;
   logic        half1_ff;
   logic [29:0] mag1_ff;
   logic [14:0] q1_ff;
   logic [6:0]  r1_ff;
   logic [18:0] low_ff;
   logic [31:0] phase_ff;

   logic [29:0] mag1_in;
   logic [39:0] num;
   hvd_pkg::div90_type hi_div;
   logic [25:0] part;
   hvd_pkg::div90_type lo_div;
   logic [33:0] quo;
   logic [31:0] phase_in;

   assign mag1_in = angle[29] ? 30'(-angle) : 30'(angle);

   // Round to nearest: (m * 2^k + 45) / 90, split into two short divisions
   always_comb begin
      num = (half1_ff ? ({10'd0, mag1_ff} << 9) : ({10'd0, mag1_ff} << 10)) + 40'd45;
      hi_div = hvd_pkg::div90({5'd0, num[39:19]});
   end

   always_comb begin
      part     = {r1_ff, 19'd0} + {7'd0, low_ff};
      lo_div   = hvd_pkg::div90(part);
      quo      = {q1_ff, 19'd0} + {14'd0, lo_div.quo};
      phase_in = neg2_ff ? (32'd0 - quo[31:0]) : quo[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff  <= angle[29];
         half1_ff <= half_turn;
         mag1_ff  <= mag1_in;
         neg2_ff  <= neg1_ff;
         q1_ff    <= hi_div.quo[14:0];
         r1_ff    <= hi_div.rem;
         low_ff   <= num[18:0];
         phase_ff <= phase_in;
      end
   end

   assign out_valid = v3_ff;
   assign phase     = phase_ff;

endmodule

@@ hw/rtl/hvd_sincos.sv @@
// Pipelined rotation-mode CORDIC giving the sine or cosine of a phase.
module hvd_sincos (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [31:0]         phase,
   input  logic                sel_sine,
   output logic                out_valid,
   output hvd_pkg::cw_type     trig
);

   localparam int N = hvd_pkg::CORDIC_STAGES;

   logic            v0_ff;
   logic [1:0]      q0_ff;
   hvd_pkg::cw_type z0_ff;
   logic            sel_ff [0:N];
   logic            v_ff   [1:N];
   logic [1:0]      q_ff   [1:N];
   hvd_pkg::cw_type x_ff   [1:N];
   hvd_pkg::cw_type y_ff   [1:N];
   hvd_pkg::cw_type z_ff   [1:N];
   logic            vo_ff;
   hvd_pkg::cw_type trig_ff;

   logic [31:0]     turn_sum;
   logic [1:0]      q0_in;
   logic [31:0]     rr;
   logic [31:0]     mag;
   logic [63:0]     prod;
   logic [32:0]     zm;
   hvd_pkg::cw_type z0_in;
   hvd_pkg::cw_type cos_v, sin_v;

   // Fold into the octant around the nearest axis, then scale to Q30 radians
   always_comb begin
      turn_sum = phase + 32'h2000_0000;
      q0_in    = turn_sum[31:30];
      rr       = phase - {q0_in, 30'd0};
      mag      = rr[31] ? (32'd0 - rr) : rr;
      prod     = {32'd0, mag} * {32'd0, hvd_pkg::PI_Q30};
      zm       = 33'((prod + 64'd1073741824) >> 31);
      z0_in    = rr[31] ? -hvd_pkg::cw_type'({1'b0, zm}) : hvd_pkg::cw_type'({1'b0, zm});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q0_ff     <= q0_in;
         z0_ff     <= z0_in;
         sel_ff[0] <= sel_sine;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic            v_cur;
      logic [1:0]      q_cur;
      hvd_pkg::cw_type x_cur, y_cur, z_cur, xs, ys;
      hvd_pkg::cw_type x_in, y_in, z_in;

      if (k == 0) begin : g_first
         assign v_cur = v0_ff;
         assign q_cur = q0_ff;
         assign x_cur = hvd_pkg::GAIN_INV_Q30;
         assign y_cur = '0;
         assign z_cur = z0_ff;
      end else begin : g_next
         assign v_cur = v_ff[k];
         assign q_cur = q_ff[k];
         assign x_cur = x_ff[k];
         assign y_cur = y_ff[k];
         assign z_cur = z_ff[k];
      end

      always_comb begin
         xs = x_cur >>> k;
         ys = y_cur >>> k;
         if (!z_cur[33]) begin
            x_in = x_cur - ys;
            y_in = y_cur + xs;
            z_in = z_cur - hvd_pkg::ATAN_Q30[k];
         end else begin
            x_in = x_cur + ys;
            y_in = y_cur - xs;
            z_in = z_cur + hvd_pkg::ATAN_Q30[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (enable) begin
            v_ff[k+1] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            q_ff[k+1]   <= q_cur;
            x_ff[k+1]   <= x_in;
            y_ff[k+1]   <= y_in;
            z_ff[k+1]   <= z_in;
            sel_ff[k+1] <= sel_ff[k];
         end
      end
   end

   // Undo the quadrant fold
   always_comb begin
      unique case (q_ff[N])
         2'd0: begin
            cos_v = x_ff[N];
            sin_v = y_ff[N];
         end
         2'd1: begin
            cos_v = -y_ff[N];
            sin_v = x_ff[N];
         end
         2'd2: begin
            cos_v = -x_ff[N];
            sin_v = -y_ff[N];
         end
         default: begin
            cos_v = y_ff[N];
            sin_v = -x_ff[N];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (enable) begin
         vo_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff <= sel_ff[N] ? sin_v : cos_v;
      end
   end

   assign out_valid = vo_ff;
   assign trig      = trig_ff;

endmodule

@@ hw/rtl/hvd_sqrt.sv @@
// Pipelined floor square root of a Q30 value, one result bit per stage.
module hvd_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [30:0] value,
   output logic        out_valid,
   output logic [30:0] root
);

   localparam int N = hvd_pkg::ISQRT_STEPS;

   logic        v_ff [1:N];
   logic [62:0] n_ff [1:N];
   logic [62:0] r_ff [1:N];

   for (genvar j = 1; j <= N; j++) begin : g_step
      localparam logic [62:0] BitC = 63'd1 << (62 - 2 * j);
      logic        v_cur;
      logic [62:0] n_cur, r_cur, trial;
      logic [62:0] n_in, r_in;

      if (j == 1) begin : g_first
         assign v_cur = in_valid;
         assign n_cur = {2'd0, value, 30'd0};
         assign r_cur = '0;
      end else begin : g_next
         assign v_cur = v_ff[j-1];
         assign n_cur = n_ff[j-1];
         assign r_cur = r_ff[j-1];
      end

      always_comb begin
         trial = r_cur + BitC;
         if (n_cur >= trial) begin
            n_in = n_cur - trial;
            r_in = (r_cur >> 1) + BitC;
         end else begin
            n_in = n_cur;
            r_in = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (enable) begin
            v_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[j] <= n_in;
            r_ff[j] <= r_in;
         end
      end
   end

   assign out_valid = v_ff[N];
   assign root      = r_ff[N][30:0];

endmodule

@@ hw/rtl/hvd_vector.sv @@
// Pipelined vectoring-mode CORDIC giving the angle of (x, y) in Q30 radians.
module hvd_vector (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  logic [30:0]     x_val,
   input  logic [30:0]     y_val,
   output logic            out_valid,
   output hvd_pkg::cw_type angle
);

   localparam int N = hvd_pkg::CORDIC_STAGES;

   logic            v_ff [1:N];
   hvd_pkg::vw_type x_ff [1:N];
   hvd_pkg::vw_type y_ff [1:N];
   hvd_pkg::cw_type z_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic            v_cur;
      hvd_pkg::vw_type x_cur, y_cur, xs, ys, x_in, y_in;
      hvd_pkg::cw_type z_cur, z_in;

      if (k == 0) begin : g_first
         assign v_cur = in_valid;
         assign x_cur = hvd_pkg::vw_type'({4'd0, x_val});
         assign y_cur = hvd_pkg::vw_type'({4'd0, y_val});
         assign z_cur = '0;
      end else begin : g_next
         assign v_cur = v_ff[k];
         assign x_cur = x_ff[k];
         assign y_cur = y_ff[k];
         assign z_cur = z_ff[k];
      end

      // Drive y towards zero, accumulating the rotation
      always_comb begin
         xs = x_cur >>> k;
         ys = y_cur >>> k;
         if (!y_cur[34]) begin
            x_in = x_cur + ys;
            y_in = y_cur - xs;
            z_in = z_cur + hvd_pkg::ATAN_Q30[k];
         end else begin
            x_in = x_cur - ys;
            y_in = y_cur + xs;
            z_in = z_cur - hvd_pkg::ATAN_Q30[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (enable) begin
            v_ff[k+1] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k+1] <= x_in;
            y_ff[k+1] <= y_in;
            z_ff[k+1] <= z_in;
         end
      end
   end

   assign out_valid = v_ff[N];
   assign angle     = z_ff[N];

endmodule
